[rtl/les_pkg.sv]
// Shared types, constants and the day-class match function for the light event scheduler.
// Depends on nothing; every other file imports it.
package les_pkg;

  localparam int TABLE_DEPTH_DEF   = 64;
  localparam int LIGHT_ID_BITS_DEF = 8;
  localparam int LIGHT_OUT_BITS    = 8;
  localparam int DAY_BITS          = 4;
  localparam int MINUTE_BITS       = 11;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [DAY_BITS-1:0] DAY_FRI     = 4'd4;
  localparam logic [DAY_BITS-1:0] DAY_SAT     = 4'd5;
  localparam logic [DAY_BITS-1:0] DAY_SUN     = 4'd6;
  localparam logic [DAY_BITS-1:0] DAY_WEEKDAY = 4'd7;
  localparam logic [DAY_BITS-1:0] DAY_WEEKEND = 4'd8;
  localparam logic [DAY_BITS-1:0] DAY_EVERY   = 4'd9;

  typedef struct packed {
    logic                      operation;
    logic [LIGHT_OUT_BITS-1:0] light_id;
    logic [DAY_BITS-1:0]       day_code;
    logic [MINUTE_BITS-1:0]    minute_of_day;
    logic                      turn_on;
  } les_in_t;

  typedef struct packed {
    logic [LIGHT_OUT_BITS-1:0] light_id_res;
    logic                      switch_on;
    logic                      last;
  } les_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic add_we;   // store the accepted add beat
    logic start;    // accept a tick and rewind the scan
    logic advance;  // move the scan one slot on
    logic flush;    // emit the held match as the final command
  } les_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic idx_done;    // every filled slot has been read
    logic rd_valid;    // read stage holds an entry
    logic pend_valid;  // a match is held back for the last flag
    logic hit;         // read stage entry matches the tick
    logic out_free;    // output register can take a beat this cycle
  } les_stat_t;

  function automatic logic day_match(input logic [DAY_BITS-1:0] stored,
                                     input logic [DAY_BITS-1:0] now);
    logic m;
    case (stored)
      DAY_WEEKDAY: m = (now <= DAY_FRI);
      DAY_WEEKEND: m = (now == DAY_SAT) || (now == DAY_SUN);
      DAY_EVERY:   m = 1'b1;
      default:     m = (stored == now);
    endcase
    return m;
  endfunction

endpackage

[rtl/les_ctrl.sv]
// Controller state machine of the light event scheduler: input handshake and scan sequencing.
// Depends on les_pkg for the command and status structs and operation codes.
module les_ctrl
  import les_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_op,
  input  les_stat_t stat,
  output logic      in_stall,
  output les_cmd_t  cmd
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t state;
  logic   scan_empty;

  assign scan_empty = stat.idx_done && !stat.rd_valid;
  assign in_stall   = (state != ST_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_TICK) begin
            cmd.start = 1'b1;
          end else begin
            cmd.add_we = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (scan_empty) begin
          cmd.flush = stat.pend_valid && stat.out_free;
        end else begin
          // hold when a second match needs the output register and it is busy
          cmd.advance = !(stat.hit && stat.pend_valid && !stat.out_free);
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && (in_op == OP_TICK)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_empty && (!stat.pend_valid || stat.out_free)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/les_dp.sv]
// Datapath of the light event scheduler: entry memory, fill count, scan read stage,
// held match and output register. Depends on les_pkg; driven by les_ctrl commands.
module les_dp
  import les_pkg::*;
#(
  parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
  parameter int LIGHT_ID_BITS = LIGHT_ID_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  les_in_t   in_beat,
  input  les_cmd_t  cmd,
  input  logic      out_stall,
  output les_stat_t stat,
  output logic      out_valid,
  output les_out_t  out_beat
);

  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IdW   = (LIGHT_ID_BITS > LIGHT_OUT_BITS) ? LIGHT_ID_BITS : LIGHT_OUT_BITS;

  // entry memory, filled from slot 0 upwards
  logic [LIGHT_ID_BITS-1:0] mem_light  [TABLE_DEPTH];
  logic [DAY_BITS-1:0]      mem_day    [TABLE_DEPTH];
  logic [MINUTE_BITS-1:0]   mem_minute [TABLE_DEPTH];
  logic                     mem_action [TABLE_DEPTH];

  logic [CntW-1:0]          count;
  logic [CntW-1:0]          idx;
  logic [DAY_BITS-1:0]      tick_day;
  logic [MINUTE_BITS-1:0]   tick_min;

  logic                     rd_valid;
  logic [LIGHT_ID_BITS-1:0] rd_light;
  logic [DAY_BITS-1:0]      rd_day;
  logic [MINUTE_BITS-1:0]   rd_minute;
  logic                     rd_action;

  logic                     pend_valid;
  logic [LIGHT_ID_BITS-1:0] pend_light;
  logic                     pend_action;

  logic [IdW-1:0]           id_in_wide;
  logic [IdW-1:0]           id_out_wide;
  logic                     full;
  logic                     do_write;
  logic                     do_read;
  logic                     hit;
  logic                     push_mid;
  logic                     out_free;

  assign id_in_wide  = IdW'(in_beat.light_id);
  assign id_out_wide = IdW'(pend_light);
  assign full        = (count == CntW'(TABLE_DEPTH));
  assign do_write    = cmd.add_we && !full;
  assign do_read     = cmd.advance && (idx != count);
  assign hit         = rd_valid && (rd_minute == tick_min) && day_match(rd_day, tick_day);
  assign out_free    = !out_valid || !out_stall;
  assign push_mid    = cmd.advance && hit && pend_valid;

  assign stat.idx_done   = (idx == count);
  assign stat.rd_valid   = rd_valid;
  assign stat.pend_valid = pend_valid;
  assign stat.hit        = hit;
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem_light[count[AddrW-1:0]]  <= id_in_wide[LIGHT_ID_BITS-1:0];
      mem_day[count[AddrW-1:0]]    <= in_beat.day_code;
      mem_minute[count[AddrW-1:0]] <= in_beat.minute_of_day;
      mem_action[count[AddrW-1:0]] <= in_beat.turn_on;
    end
    if (do_read) begin
      rd_light  <= mem_light[idx[AddrW-1:0]];
      rd_day    <= mem_day[idx[AddrW-1:0]];
      rd_minute <= mem_minute[idx[AddrW-1:0]];
      rd_action <= mem_action[idx[AddrW-1:0]];
    end
  end

  // fill count and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (do_write) begin
        count <= count + 1'b1;
      end
      if (cmd.start) begin
        idx      <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.advance) begin
        rd_valid <= do_read;
        if (do_read) begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.start) begin
        pend_valid <= 1'b0;
      end else if (cmd.advance && hit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (push_mid || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tick_day <= in_beat.day_code;
      tick_min <= in_beat.minute_of_day;
    end
    if (cmd.advance && hit) begin
      pend_light  <= rd_light;
      pend_action <= rd_action;
    end
    if (push_mid || cmd.flush) begin
      out_beat.light_id_res <= id_out_wide[LIGHT_OUT_BITS-1:0];
      out_beat.switch_on    <= pend_action;
      out_beat.last         <= cmd.flush;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CntW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  assert property (@(posedge clk) disable iff (rst) (push_mid || cmd.flush) |-> out_free)
    else $error("beat loaded into a busy output register");

  assert property (@(posedge clk) disable iff (rst) cmd.start |=> (!rd_valid && !pend_valid))
    else $error("scan state not cleared at tick start");

  assert property (@(posedge clk) disable iff (rst) cmd.flush |=> !pend_valid)
    else $error("held match survived the final command");

endmodule

[rtl/light_event_scheduler_unit.sv]
// Top level of the light event scheduler: joins the controller and the datapath.
// Depends on les_pkg, les_ctrl and les_dp.
//
// A table of up to TABLE_DEPTH scheduled light events. An add beat (operation 0) stores its
// light, day class, minute and action in the next free slot and gives no result; once the
// table is full further adds are dropped without notice. A tick beat (operation 1) carries
// the current weekday (0 Monday .. 6 Sunday) and minute; the table is read back one slot per
// cycle while out_stall does not hold the scan, from the single read port of the entry
// memory, in slot order, and each entry that matches the minute and day class (exact day,
// weekday, weekend or every day) gives one output beat. The final beat of a tick has last
// set, so one match is always held back until the next match or the end of the scan. A
// tick keeps in_stall high until its scan ends, also while out_stall holds the scan. A
// tick that matches nothing gives no beat at all. The valid state of the table is a fill
// count cleared by rst, so no clearing pass follows reset. The output register lets the
// next input beat be taken while the last result still waits.
module light_event_scheduler_unit
  import les_pkg::*;
#(
  parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
  parameter int LIGHT_ID_BITS = LIGHT_ID_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  les_in_t  in_beat,
  output logic     out_valid,
  input  logic     out_stall,
  output les_out_t out_beat
);

  les_cmd_t  cmd;
  les_stat_t stat;

  // sequence adds and scans; stall the input for the whole of a tick
  les_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_beat.operation),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // hold the table, compare each read entry and drive the output beats
  les_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .LIGHT_ID_BITS (LIGHT_ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

endmodule

[tb/les_command_tracker.sv]
// Command tracker for the light event scheduler: watches both channels, keeps its own copy
// of the event table, predicts the switch commands of every tick and compares them in order.
// Depends on les_pkg; instantiated beside the block by light_event_scheduler_unit_test.
`timescale 1ns / 100ps

module les_command_tracker
  import les_pkg::*;
#(
  parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
  parameter int LIGHT_ID_BITS = LIGHT_ID_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_stall,
  input  les_in_t  in_beat,
  input  logic     out_valid,
  input  logic     out_stall,
  input  les_out_t out_beat,
  output int       fail_count,
  output int       pending
);

  // Own copy of the table; slots fill in order and are never freed
  logic [LIGHT_ID_BITS-1:0] slot_light  [TABLE_DEPTH];
  logic [DAY_BITS-1:0]      slot_day    [TABLE_DEPTH];
  logic [MINUTE_BITS-1:0]   slot_minute [TABLE_DEPTH];
  logic                     slot_on     [TABLE_DEPTH];
  int                       filled;
  les_out_t                 due_commands [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    filled     = 0;
  end

  function automatic bit day_fits(input logic [DAY_BITS-1:0] stored,
                                  input logic [DAY_BITS-1:0] now);
    bit workday;
    bit restday;
    workday = (now <= DAY_FRI);
    restday = (now == DAY_SAT) || (now == DAY_SUN);
    if (stored == DAY_EVERY) return 1'b1;
    if (stored == DAY_WEEKDAY) return workday;
    if (stored == DAY_WEEKEND) return restday;
    return stored == now;
  endfunction

  // Drop the add once every slot is taken
  task automatic store_entry(input les_in_t b);
    if (filled < TABLE_DEPTH) begin
      slot_light[filled]  = LIGHT_ID_BITS'(b.light_id);
      slot_day[filled]    = b.day_code;
      slot_minute[filled] = b.minute_of_day;
      slot_on[filled]     = b.turn_on;
      filled++;
    end
  endtask

  task automatic scan_tick(input les_in_t b);
    les_out_t hits [$];
    les_out_t cmd;
    for (int s = 0; s < filled; s++) begin
      if (slot_minute[s] == b.minute_of_day && day_fits(slot_day[s], b.day_code)) begin
        cmd.light_id_res = LIGHT_OUT_BITS'(slot_light[s]);
        cmd.switch_on    = slot_on[s];
        cmd.last         = 1'b0;
        hits.push_back(cmd);
      end
    end
    if (hits.size() > 0) begin
      cmd      = hits.pop_back();
      cmd.last = 1'b1;
      hits.push_back(cmd);
    end
    foreach (hits[k]) due_commands.push_back(hits[k]);
  endtask

  task automatic check_command(input les_out_t got);
    les_out_t want;
    if (due_commands.size() == 0) begin
      $error("command beat with nothing due: light_id_res %0d switch_on %0d last %0d",
             got.light_id_res, got.switch_on, got.last);
      fail_count++;
    end else begin
      want = due_commands.pop_front();
      if (got.light_id_res !== want.light_id_res) begin
        $error("light_id_res: expected %0d, got %0d", want.light_id_res, got.light_id_res);
        fail_count++;
      end
      if (got.switch_on !== want.switch_on) begin
        $error("switch_on: expected %0d, got %0d", want.switch_on, got.switch_on);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fail_count++;
      end
    end
  endtask

  // Results of a tick cannot leave at the edge that takes the tick, so retire the
  // output beat before adding what the input beat predicts
  always @(posedge clk) begin
    if (rst) begin
      filled = 0;
      due_commands.delete();
    end else begin
      if (out_valid && !out_stall) check_command(out_beat);
      if (in_valid && !in_stall) begin
        if (in_beat.operation == OP_TICK) scan_tick(in_beat);
        else store_entry(in_beat);
      end
    end
    pending = due_commands.size();
  end

endmodule

[tb/light_event_scheduler_unit_test.sv]
// Top of the light event scheduler testbench: clock, reset, stimulus and verdict.
// Depends on les_pkg, light_event_scheduler_unit and les_command_tracker.
`timescale 1ns / 100ps

module light_event_scheduler_unit_test;
  import les_pkg::*;

  localparam int RANDOM_ITEMS = 410;  // beats sent after the directed part
  localparam int DRAIN_CYCLES = 80;   // covers a full scan that matches nothing
  localparam int LONG_HOLD    = 400;  // cycles of the one long receiver hold-off
  localparam int HOLD_AFTER   = 30;   // command beats seen before the hold-off starts
  localparam int unsigned RUN_LIMIT_NS = 40_000_000;

  localparam logic [DAY_BITS-1:0] DAY_MON        = 4'd0;
  localparam logic [DAY_BITS-1:0] DAY_WED        = 4'd2;
  localparam logic [DAY_BITS-1:0] DAY_CODE_SPARE = 4'd10;
  localparam logic [DAY_BITS-1:0] DAY_CODE_MID   = 4'd12;
  localparam logic [DAY_BITS-1:0] DAY_CODE_TOP   = 4'd15;

  typedef enum int {FLOW_FREE, FLOW_CHOPPY, FLOW_CHOKED} flow_t;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  les_in_t  in_beat   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  les_out_t out_beat;

  int fail_count;
  int pending;
  int results_seen = 0;
  int burst_left   = 0;
  logic [MINUTE_BITS-1:0] minute_pool [8];

  always #6 clk = ~clk;

  light_event_scheduler_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  les_command_tracker i_tracker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic les_in_t make_add(input logic [LIGHT_OUT_BITS-1:0] light,
                                       input logic [DAY_BITS-1:0] day,
                                       input logic [MINUTE_BITS-1:0] minute,
                                       input logic on_now);
    les_in_t b;
    b.operation     = OP_ADD;
    b.light_id      = light;
    b.day_code      = day;
    b.minute_of_day = minute;
    b.turn_on       = on_now;
    return b;
  endfunction

  // A tick ignores light and action; fill them with noise all the same
  function automatic les_in_t make_tick(input logic [DAY_BITS-1:0] day,
                                        input logic [MINUTE_BITS-1:0] minute);
    les_in_t b;
    b.operation     = OP_TICK;
    b.light_id      = LIGHT_OUT_BITS'($urandom);
    b.day_code      = day;
    b.minute_of_day = minute;
    b.turn_on       = 1'($urandom_range(1));
    return b;
  endfunction

  // Mostly draw from a small set of minutes so that ticks find matches; now and then
  // take any 11-bit value, out-of-day minutes included
  function automatic logic [MINUTE_BITS-1:0] pick_minute();
    if ($urandom_range(99) < 85) return minute_pool[$urandom_range(7)];
    return MINUTE_BITS'($urandom_range(2047));
  endfunction

  // Offer one beat and hold it until taken. The sender works in bursts: when a burst
  // runs out, drop valid for a random gap (sometimes none) and start a new burst.
  // Valid is only raised here or lowered after acceptance, never both in one step.
  task automatic send_beat(input les_in_t b);
    int gap;
    in_valid <= 1'b1;
    in_beat  <= b;
    do begin
      @(posedge clk);
    end while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      burst_left = $urandom_range(30, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Count command beats as they leave; nonblocking so the receiver reads a settled value
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) results_seen <= results_seen + 1;
  end

  // Receiver: stall on a pattern of its own, switching between free flow, choppy and
  // mostly stalled stretches of random length. Once, after the first few dozen command
  // beats, hold off for a long stretch so that the block backs up and stalls its input
  // while the sender keeps offering.
  initial begin : receiver
    flow_t style;
    int    run_left;
    int    hold_left;
    bit    held_once;
    style     = FLOW_FREE;
    run_left  = 0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && results_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          style    = flow_t'($urandom_range(2));
          run_left = $urandom_range(200, 20);
        end
        run_left--;
        case (style)
          FLOW_FREE:   out_stall <= 1'b0;
          FLOW_CHOPPY: out_stall <= 1'($urandom_range(1));
          default:     out_stall <= ($urandom_range(9) < 8);
        endcase
      end
    end
  end

  initial begin : stimulus
    les_in_t             b;
    int                  counted;
    int                  adds_taken;
    bit                  want_add;
    logic [DAY_BITS-1:0] day;
    counted        = 0;
    minute_pool[0] = '0;
    minute_pool[1] = 11'd1439;
    minute_pool[2] = '1;
    for (int k = 3; k < 8; k++) minute_pool[k] = MINUTE_BITS'($urandom_range(1439));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Fill a few slots covering every day class, the field extremes,
    // a duplicate pair, two unused day codes and a minute past the end of the day.
    send_beat(make_add(8'h00, DAY_MON, 11'd0, 1'b1));
    send_beat(make_add(8'hFF, DAY_SUN, 11'd1439, 1'b0));
    send_beat(make_add(8'hA5, DAY_WEEKDAY, 11'd600, 1'b1));
    send_beat(make_add(8'h5A, DAY_WEEKEND, 11'd600, 1'b0));
    send_beat(make_add(8'h3C, DAY_EVERY, 11'd600, 1'b1));
    send_beat(make_add(8'h3C, DAY_EVERY, 11'd600, 1'b1));
    send_beat(make_add(8'h81, DAY_CODE_TOP, 11'd2047, 1'b1));
    send_beat(make_add(8'h42, DAY_CODE_SPARE, 11'd720, 1'b0));
    send_beat(make_add(8'h7E, DAY_FRI, 11'd600, 1'b0));
    adds_taken = 9;

    // Exact days at both ends of the day
    send_beat(make_tick(DAY_MON, 11'd0));
    send_beat(make_tick(DAY_SUN, 11'd1439));
    // Friday: weekday, every-day and exact Friday fire; weekend must stay quiet
    send_beat(make_tick(DAY_FRI, 11'd600));
    send_beat(make_tick(DAY_SAT, 11'd600));
    send_beat(make_tick(DAY_SUN, 11'd600));
    // Unused day codes match only an entry stored with the same code
    send_beat(make_tick(DAY_CODE_TOP, 11'd2047));
    send_beat(make_tick(DAY_CODE_SPARE, 11'd720));
    // Tick days outside Monday..Sunday: only every-day entries fire
    send_beat(make_tick(DAY_WEEKDAY, 11'd600));
    send_beat(make_tick(DAY_CODE_MID, 11'd600));
    // Ticks that match nothing
    send_beat(make_tick(DAY_WED, 11'd601));
    send_beat(make_tick(DAY_SAT, 11'd0));
    send_beat(make_tick(DAY_MON, 11'd2047));

    // Random part. Favour adds until the table is full, then mostly ticks; adds that
    // arrive on a full table are dropped by the block.
    while (counted < RANDOM_ITEMS) begin
      if (adds_taken < TABLE_DEPTH_DEF) want_add = ($urandom_range(99) < 60);
      else want_add = ($urandom_range(99) < 10);
      if (want_add) begin
        if ($urandom_range(9) == 0) day = DAY_BITS'($urandom_range(DAY_CODE_TOP, DAY_EVERY + 1));
        else day = DAY_BITS'($urandom_range(DAY_EVERY));
        b = make_add(LIGHT_OUT_BITS'($urandom_range(255)), day, pick_minute(),
                     1'($urandom_range(1)));
        adds_taken++;
      end else begin
        if ($urandom_range(9) < 8) day = DAY_BITS'($urandom_range(DAY_SUN));
        else day = DAY_BITS'($urandom_range(DAY_CODE_TOP, DAY_WEEKDAY));
        b = make_tick(day, pick_minute());
      end
      counted++;
      send_beat(b);
    end

    // Drain: wait for every predicted command, then cover a last silent scan
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("light_event_scheduler_unit: match");
    end else begin
      $display("light_event_scheduler_unit: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("light_event_scheduler_unit: mismatch");
    $finish;
  end

endmodule
